[rtl/hsgn_pkg.sv]
`default_nettype none
package hsgn_pkg;

    localparam int COEF_BITS = 16;
    localparam int PIX_W     = 16;
    localparam int LIM_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = LIM_W;

    // LL after the optional shift, neighbor differences, nudged details, butterfly sums
    localparam int LL_W     = COEF_BITS + 1;
    localparam int DIFF_W   = LL_W + 1;
    localparam int NUDGE_W  = COEF_BITS + 2;
    localparam int ACC_W    = NUDGE_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_H  = 2'd0,
        REG_LIMIT_V  = 2'd1,
        REG_LL_SHIFT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_FULL    = 2'd0,
        KIND_ODD_COL = 2'd1,
        KIND_ODD_ROW = 2'd2,
        KIND_CORNER  = 2'd3
    } block_kind_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [PIX_W-1:0]     pix_t;

    typedef struct packed {
        coef_t       ll;
        coef_t       lh;
        coef_t       hl;
        coef_t       hh;
        coef_t       ll_left;
        coef_t       ll_right;
        coef_t       ll_up;
        coef_t       ll_down;
        logic        interior_x;
        logic        interior_y;
        block_kind_t block_kind;
    } quad_t;

    typedef struct packed {
        logic               en;
        logic [LIM_W-1:0]   lim;
    } nudge_ctl_t;

    // Divide by 4 truncating toward zero, then saturate to the pixel range.
    function automatic pix_t div4_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] bias;
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] q;
        pix_t                  r;
        bias = v[ACC_W-1] ? (ACC_W+1)'(3) : '0;
        t    = {v[ACC_W-1], v} + bias;
        q    = t >>> 2;
        if (q[ACC_W:PIX_W-1] != {(ACC_W-PIX_W+2){q[ACC_W]}})
        begin
            r = q[ACC_W] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
        end
        else
        begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/hsgn_if.sv]
`default_nettype none
interface hsgn_coef_if;
    import hsgn_pkg::*;

    logic        valid;
    logic        ready;
    coef_t       ll;
    coef_t       lh;
    coef_t       hl;
    coef_t       hh;
    coef_t       ll_left;
    coef_t       ll_right;
    coef_t       ll_up;
    coef_t       ll_down;
    logic        interior_x;
    logic        interior_y;
    logic [1:0]  block_kind;

    modport source (
        output valid, ll, lh, hl, hh, ll_left, ll_right, ll_up, ll_down,
               interior_x, interior_y, block_kind,
        input  ready
    );
    modport sink (
        input  valid, ll, lh, hl, hh, ll_left, ll_right, ll_up, ll_down,
               interior_x, interior_y, block_kind,
        output ready
    );
endinterface

interface hsgn_pix_if;
    import hsgn_pkg::*;

    logic  valid;
    logic  ready;
    pix_t  pix_top_left;
    pix_t  pix_top_right;
    pix_t  pix_bottom_left;
    pix_t  pix_bottom_right;

    modport source (
        output valid, pix_top_left, pix_top_right, pix_bottom_left, pix_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, pix_top_left, pix_top_right, pix_bottom_left, pix_bottom_right,
        output ready
    );
endinterface
`default_nettype wire

[rtl/haar_synthesis_with_gradient_nudge.sv]
`default_nettype none
// Inverse 2x2 Haar synthesis with gradient-guided nudging of the detail
// coefficients. One quad transaction enters per cycle and one pixel
// transaction leaves per quad via the input and result registers when the
// output is not stalled; nudge and butterfly logic between the two
// registers makes the four pixels. Throughput is one quad per cycle when
// unstalled, set by the single result register; a pixel-side stall still
// lets one more quad into the input register. Configuration (nudge limits,
// LL shift) is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, which it does not enforce;
// unknown indexes are ignored. Unproduced pixels of a block kind are zero.
module haar_synthesis_with_gradient_nudge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    hsgn_coef_if.sink                                coef,
    hsgn_pix_if.source                               pix,
    input  wire logic                                cfg_we,
    input  wire logic [hsgn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hsgn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import hsgn_pkg::*;

    // configuration registers
    logic [LIM_W-1:0] limit_h_reg;
    logic [LIM_W-1:0] limit_v_reg;
    logic             ll_shift_reg;

    // input stage
    logic             s1_valid_reg;
    quad_t            s1_quad_reg;

    // result stage
    logic             s2_valid_reg;
    pix_t             tl_reg;
    pix_t             tr_reg;
    pix_t             bl_reg;
    pix_t             br_reg;

    logic             stall;
    logic             s1_load;
    logic             s2_load;

    logic signed [LL_W-1:0]    ll_s;
    logic signed [LL_W-1:0]    left_s;
    logic signed [LL_W-1:0]    right_s;
    logic signed [LL_W-1:0]    up_s;
    logic signed [LL_W-1:0]    down_s;
    nudge_ctl_t                ctl_h;
    nudge_ctl_t                ctl_v;
    logic signed [NUDGE_W-1:0] lh_n;
    logic signed [NUDGE_W-1:0] hl_n;

    logic signed [ACC_W-1:0]   a_ll;
    logic signed [ACC_W-1:0]   a_lh;
    logic signed [ACC_W-1:0]   a_hl;
    logic signed [ACC_W-1:0]   a_hh;
    logic signed [ACC_W-1:0]   s0;
    logic signed [ACC_W-1:0]   s1;
    logic signed [ACC_W-1:0]   d0;
    logic signed [ACC_W-1:0]   d1;
    pix_t                      tl_next;
    pix_t                      tr_next;
    pix_t                      bl_next;
    pix_t                      br_next;

    // Hold everything while a finished result waits; the input stage may
    // still fill if it is empty.
    assign stall      = s2_valid_reg && !pix.ready;
    assign s2_load    = !stall;
    assign s1_load    = !s1_valid_reg || !stall;
    assign coef.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_h_reg  <= '0;
            limit_v_reg  <= '0;
            ll_shift_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIMIT_H:  limit_h_reg  <= cfg_wdata[LIM_W-1:0];
                REG_LIMIT_V:  limit_v_reg  <= cfg_wdata[LIM_W-1:0];
                REG_LL_SHIFT: ll_shift_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= coef.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && coef.valid)
        begin
            s1_quad_reg.ll         <= coef.ll;
            s1_quad_reg.lh         <= coef.lh;
            s1_quad_reg.hl         <= coef.hl;
            s1_quad_reg.hh         <= coef.hh;
            s1_quad_reg.ll_left    <= coef.ll_left;
            s1_quad_reg.ll_right   <= coef.ll_right;
            s1_quad_reg.ll_up      <= coef.ll_up;
            s1_quad_reg.ll_down    <= coef.ll_down;
            s1_quad_reg.interior_x <= coef.interior_x;
            s1_quad_reg.interior_y <= coef.interior_y;
            s1_quad_reg.block_kind <= block_kind_t'(coef.block_kind);
        end
        if (s2_load && s1_valid_reg)
        begin
            tl_reg <= tl_next;
            tr_reg <= tr_next;
            bl_reg <= bl_next;
            br_reg <= br_next;
        end
    end

    // Scale every LL value by the overflow-safety shift.
    always_comb
    begin
        ll_s    = ll_shift_reg ? {s1_quad_reg.ll, 1'b0}       : LL_W'(s1_quad_reg.ll);
        left_s  = ll_shift_reg ? {s1_quad_reg.ll_left, 1'b0}  : LL_W'(s1_quad_reg.ll_left);
        right_s = ll_shift_reg ? {s1_quad_reg.ll_right, 1'b0} : LL_W'(s1_quad_reg.ll_right);
        up_s    = ll_shift_reg ? {s1_quad_reg.ll_up, 1'b0}    : LL_W'(s1_quad_reg.ll_up);
        down_s  = ll_shift_reg ? {s1_quad_reg.ll_down, 1'b0}  : LL_W'(s1_quad_reg.ll_down);

        // Nudge only full quads that are interior, with a nonzero limit.
        ctl_h.en  = (s1_quad_reg.block_kind == KIND_FULL) && s1_quad_reg.interior_x
                    && (limit_h_reg != '0);
        ctl_h.lim = limit_h_reg;
        ctl_v.en  = (s1_quad_reg.block_kind == KIND_FULL) && s1_quad_reg.interior_y
                    && (limit_v_reg != '0);
        ctl_v.lim = limit_v_reg;
    end

    hsgn_nudge u_nudge_h (
        .ctl     (ctl_h),
        .det     (s1_quad_reg.lh),
        .ll_prev (left_s),
        .ll_cur  (ll_s),
        .ll_next (right_s),
        .det_out (lh_n)
    );

    hsgn_nudge u_nudge_v (
        .ctl     (ctl_v),
        .det     (s1_quad_reg.hl),
        .ll_prev (up_s),
        .ll_cur  (ll_s),
        .ll_next (down_s),
        .det_out (hl_n)
    );

    // Butterfly; partial kinds use reduced sums and leave the other pixels zero.
    always_comb
    begin
        a_ll = ACC_W'(ll_s);
        a_lh = ACC_W'(lh_n);
        a_hl = ACC_W'(hl_n);
        a_hh = ACC_W'(s1_quad_reg.hh);
        s0   = a_ll + a_hl;
        s1   = a_ll - a_hl;
        d0   = a_lh + a_hh;
        d1   = a_lh - a_hh;

        tl_next = '0;
        tr_next = '0;
        bl_next = '0;
        br_next = '0;
        unique case (s1_quad_reg.block_kind)
            KIND_FULL:
            begin
                tl_next = div4_sat(s0 + d0);
                tr_next = div4_sat(s0 - d0);
                bl_next = div4_sat(s1 + d1);
                br_next = div4_sat(s1 - d1);
            end
            KIND_ODD_COL:
            begin
                tl_next = div4_sat(s0);
                bl_next = div4_sat(s1);
            end
            KIND_ODD_ROW:
            begin
                tl_next = div4_sat(a_ll + a_lh);
                tr_next = div4_sat(a_ll - a_lh);
            end
            KIND_CORNER:
            begin
                tl_next = div4_sat(a_ll);
            end
            default:
            begin
                tl_next = '0;
            end
        endcase
    end

    assign pix.valid            = s2_valid_reg;
    assign pix.pix_top_left     = tl_reg;
    assign pix.pix_top_right    = tr_reg;
    assign pix.pix_bottom_left  = bl_reg;
    assign pix.pix_bottom_right = br_reg;

`ifndef SYNTHESIS
    // An accepted quad always lands in the input stage.
    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        coef.valid && coef.ready |=> s1_valid_reg)
        else $error("accepted quad did not reach the input stage");

    // A held quad advances to the result stage once the output is free.
    a_s1_advances : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !stall |=> pix.valid)
        else $error("quad in input stage did not advance");

    // Back-pressure on the input only when both stages are occupied.
    a_ready_low_full : assert property (@(posedge clk) disable iff (!rst_n)
        !coef.ready |-> s1_valid_reg && pix.valid && !pix.ready)
        else $error("input stalled with a free stage");
`endif

endmodule
`default_nettype wire

[rtl/hsgn_nudge.sv]
`default_nettype none
module hsgn_nudge (
    input  wire hsgn_pkg::nudge_ctl_t                        ctl,
    input  wire logic signed [hsgn_pkg::COEF_BITS-1:0]       det,
    input  wire logic signed [hsgn_pkg::LL_W-1:0]            ll_prev,
    input  wire logic signed [hsgn_pkg::LL_W-1:0]            ll_cur,
    input  wire logic signed [hsgn_pkg::LL_W-1:0]            ll_next,
    output logic signed [hsgn_pkg::NUDGE_W-1:0]              det_out
);
    import hsgn_pkg::*;

    localparam int LIM8_W = LIM_W + 3;
    localparam int CMP_W  = (DIFF_W > LIM8_W) ? DIFF_W : LIM8_W;
    localparam int RND_W  = DIFF_W + 2;
    localparam int N_W    = DIFF_W + 3;

    localparam logic signed [DIFF_W:0]  RND_HALF  = 4;
    localparam logic signed [RND_W-1:0] RND_TRUNC = 7;

    logic signed [DIFF_W-1:0] step_a;
    logic signed [DIFF_W-1:0] step_b;
    logic [DIFF_W-1:0]        mag_a;
    logic [DIFF_W-1:0]        mag_b;
    logic [LIM8_W-1:0]        lim8;
    logic                     ramp;
    logic signed [DIFF_W-1:0] span;
    logic signed [DIFF_W:0]   span_b;
    logic signed [RND_W-1:0]  span_t;
    logic signed [RND_W-1:0]  target;
    logic signed [LIM_W:0]    lim_s;
    logic signed [N_W-1:0]    delta;
    logic signed [N_W-1:0]    delta_c;
    logic signed [N_W-1:0]    moved;

    always_comb
    begin
        step_a = DIFF_W'(ll_cur) - DIFF_W'(ll_prev);
        step_b = DIFF_W'(ll_next) - DIFF_W'(ll_cur);
        mag_a  = step_a[DIFF_W-1] ? DIFF_W'(-step_a) : DIFF_W'(step_a);
        mag_b  = step_b[DIFF_W-1] ? DIFF_W'(-step_b) : DIFF_W'(step_b);
        lim8   = {ctl.lim, 3'b000};
        ramp   = (step_a != '0) && (step_b != '0)
                 && (step_a[DIFF_W-1] == step_b[DIFF_W-1])
                 && (CMP_W'(mag_a) < CMP_W'(lim8))
                 && (CMP_W'(mag_b) < CMP_W'(lim8));

        // round8 of the outer difference, toward zero after the half bias
        span   = DIFF_W'(ll_prev) - DIFF_W'(ll_next);
        span_b = span + (span[DIFF_W-1] ? -RND_HALF : RND_HALF);
        span_t = span_b + (span_b[DIFF_W] ? RND_TRUNC : RND_W'(0));
        target = span_t >>> 3;

        lim_s  = signed'({1'b0, ctl.lim});
        delta  = target - det;
        if (delta > lim_s)
        begin
            delta_c = N_W'(lim_s);
        end
        else if (delta < -lim_s)
        begin
            delta_c = N_W'(-lim_s);
        end
        else
        begin
            delta_c = delta;
        end

        moved = (ctl.en && ramp) ? (det + delta_c) : N_W'(det);
        det_out = moved[NUDGE_W-1:0];
    end

endmodule
`default_nettype wire
